>>> src/rqs_pkg.sv
// Shared types and constants of the ready queue scheduler.
// Used by the channel interfaces and by the scheduler top level.
`default_nettype none
package rqs_pkg;

   localparam int ID_W       = 8;
   localparam int KEY_IN_W   = 16;
   localparam int DYN_W      = 4;
   localparam int STAT_W     = 4;
   localparam int OUT_LVL_W  = 3;
   localparam int STAMP_W    = 32;
   localparam int LVLCNT_W   = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [1:0] {
      POL_FIFO = 2'd0,
      POL_LIFO = 2'd1,
      POL_SRT  = 2'd2,
      POL_PRIO = 2'd3
   } policy_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TAKE = 1'b1;

   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_LEVELS = 1'b1;

   localparam policy_type POLICY_RST = POL_FIFO;
   localparam logic [3:0] LEVELS_RST = 4'd4;

endpackage
`default_nettype wire

>>> src/rqs_req_if.sv
// Request channel of the ready queue scheduler: valid/ready plus one request word.
// Depends on rqs_pkg for field widths.
`default_nettype none
interface rqs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [rqs_pkg::ID_W-1:0]            proc_id;
   logic [rqs_pkg::KEY_IN_W-1:0]        remaining_time;
   logic signed [rqs_pkg::DYN_W-1:0]    dynamic_level;
   logic [rqs_pkg::STAT_W-1:0]          static_level;

   modport source (output valid, mode, proc_id, remaining_time, dynamic_level, static_level,
                   input ready);
   modport sink (input valid, mode, proc_id, remaining_time, dynamic_level, static_level,
                 output ready);
endinterface
`default_nettype wire

>>> src/rqs_rsp_if.sv
// Response channel of the ready queue scheduler: valid/ready plus one response word.
// Depends on rqs_pkg for field widths.
`default_nettype none
interface rqs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic [rqs_pkg::ID_W-1:0]          out_id;
   logic [rqs_pkg::OUT_LVL_W-1:0]     out_level;

   modport source (output valid, status, out_id, out_level, input ready);
   modport sink (input valid, status, out_id, out_level, output ready);
endinterface
`default_nettype wire

>>> src/rqs_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module rqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> src/ready_queue_scheduler.sv
// Ready queue scheduler top level: slot store, scan sequencer and compare unit.
// Depends on rqs_pkg, rqs_req_if, rqs_rsp_if and rqs_ram.
//
// Usage: each request word either adds a process entry (mode 0) or takes the
// next entry (mode 1) under the policy register: fifo, lifo, shortest
// remaining time, or priority with active and expired banks. Each request
// gives one response word. Registers sit behind an APB-style port: policy at
// 0x0, priority_levels at 0x4; write them only while no request is in flight.
// Sequencing: the sequencer walks the slot store one slot per cycle through the
// RAM read port and one compare unit. An add scans upward from slot 0 to the
// lowest free slot and writes there, or reports full after the last slot; a
// level out of range goes straight to the response without a scan. A fifo, lifo
// or shortest remaining take scans every slot; a priority take scans twice, for
// bank occupancy and for the pick, and only once when both banks are empty.
// Throughput: one request at a time; req ready rises at the edge that loads
// the previous response. A stalled receiver leaves the response register
// full; the next request then waits in its final state and blocks any
// further request.
// Reset (synchronous) empties the store, zeroes the arrival stamp and bank
// select, and restores the register defaults; the block is ready at once.
`default_nettype none
module ready_queue_scheduler #(
   parameter int SLOTS     = 64,
   parameter int LEVELS    = 8,
   parameter int TIME_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rqs_req_if.sink                                req_bus,
   rqs_rsp_if.source                              rsp_bus,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rqs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [rqs_pkg::CSR_DATA_W-1:0]    pwdata,
   output      logic [rqs_pkg::CSR_DATA_W-1:0]    prdata,
   output      logic                              pready
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   typedef struct packed {
      logic [rqs_pkg::STAMP_W-1:0] stamp;
      logic                        bank;
      logic [LVL_W-1:0]            lvl;
      logic [TIME_BITS-1:0]        key;
      logic [rqs_pkg::ID_W-1:0]    id;
   } slot_type;

   localparam int ENTRY_W = $bits(slot_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_TAKE,
      S_PICK,
      S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   rqs_pkg::policy_type              policy_ff, policy_in;
   logic [3:0]                       levels_ff, levels_in;
   logic                             active_ff, active_in;
   logic [rqs_pkg::STAMP_W-1:0]      arrival_ff, arrival_in;
   logic [SLOTS-1:0]                 valid_ff, valid_in;

   logic [rqs_pkg::ID_W-1:0]         it_id_ff, it_id_in;
   logic [TIME_BITS-1:0]             it_key_ff, it_key_in;
   logic [LVL_W-1:0]                 it_lvl_ff, it_lvl_in;
   logic                             it_bank_ff, it_bank_in;

   logic [IDX_W:0]                   cnt_ff, cnt_in;
   logic                             lag_live_ff, lag_live_in;
   logic                             lag_valid_ff, lag_valid_in;
   logic [IDX_W-1:0]                 lag_idx_ff, lag_idx_in;

   logic                             found_ff, found_in;
   logic [IDX_W-1:0]                 best_idx_ff, best_idx_in;
   logic [rqs_pkg::ID_W-1:0]         best_id_ff, best_id_in;
   logic [TIME_BITS-1:0]             best_key_ff, best_key_in;
   logic [LVL_W-1:0]                 best_lvl_ff, best_lvl_in;
   logic [rqs_pkg::STAMP_W-1:0]      best_age_ff, best_age_in;
   logic                             act_ff, act_in;
   logic                             exp_ff, exp_in;

   rqs_pkg::status_type              res_status_ff, res_status_in;
   logic [rqs_pkg::ID_W-1:0]         res_id_ff, res_id_in;
   logic [rqs_pkg::OUT_LVL_W-1:0]    res_lvl_ff, res_lvl_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   rqs_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [rqs_pkg::ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [rqs_pkg::OUT_LVL_W-1:0]    rsp_lvl_ff, rsp_lvl_in;

   logic                             ram_we;
   logic [IDX_W-1:0]                 ram_waddr;
   slot_type                         ram_wdata;
   logic [IDX_W-1:0]                 ram_raddr;
   logic [ENTRY_W-1:0]               ram_rdata;

   slot_type                         cand;
   logic [rqs_pkg::STAMP_W-1:0]      cand_age;
   logic                             age_gt;
   logic                             age_lt;
   logic                             wins;
   logic                             better;
   logic                             cand_in_range;
   logic [rqs_pkg::LVLCNT_W-1:0]     lvl_count;
   logic                             csr_write;

   rqs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == rqs_pkg::REG_LEVELS) ? rqs_pkg::CSR_DATA_W'(levels_ff)
                                                        : rqs_pkg::CSR_DATA_W'(policy_ff);

   assign req_bus.ready     = (state_ff == S_IDLE) && !reset;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.out_id    = rsp_id_ff;
   assign rsp_bus.out_level = rsp_lvl_ff;

   // clamp level count to 1 .. LEVELS
   always_comb begin
      if (levels_ff == 4'd0) begin
         lvl_count = rqs_pkg::LVLCNT_W'(1);
      end else if ({1'b0, levels_ff} > rqs_pkg::LVLCNT_W'(LEVELS)) begin
         lvl_count = rqs_pkg::LVLCNT_W'(LEVELS);
      end else begin
         lvl_count = {1'b0, levels_ff};
      end
   end

   // shared compare unit
   always_comb begin
      cand          = slot_type'(ram_rdata);
      cand_age      = arrival_ff - cand.stamp;
      age_gt        = cand_age > best_age_ff;
      age_lt        = cand_age < best_age_ff;
      cand_in_range = rqs_pkg::LVLCNT_W'(cand.lvl) < lvl_count;
      case (policy_ff)
         rqs_pkg::POL_LIFO: wins = age_lt;
         rqs_pkg::POL_SRT:  wins = (cand.key < best_key_ff) ||
                                   ((cand.key == best_key_ff) && age_gt);
         rqs_pkg::POL_PRIO: wins = (cand.lvl > best_lvl_ff) ||
                                   ((cand.lvl == best_lvl_ff) && age_gt);
         default:           wins = age_gt;
      endcase
      better = !found_ff || wins;
   end

   always_comb begin
      logic [3:0]                   lvl4;
      logic                         bad;
      logic                         elig;
      logic [IDX_W-1:0]             idx;
      logic [3:0]                   wide;

      state_in      = state_ff;
      policy_in     = policy_ff;
      levels_in     = levels_ff;
      active_in     = active_ff;
      arrival_in    = arrival_ff;
      valid_in      = valid_ff;
      it_id_in      = it_id_ff;
      it_key_in     = it_key_ff;
      it_lvl_in     = it_lvl_ff;
      it_bank_in    = it_bank_ff;
      cnt_in        = cnt_ff;
      lag_live_in   = lag_live_ff;
      lag_valid_in  = lag_valid_ff;
      lag_idx_in    = lag_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_key_in   = best_key_ff;
      best_lvl_in   = best_lvl_ff;
      best_age_in   = best_age_ff;
      act_in        = act_ff;
      exp_in        = exp_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_lvl_in    = res_lvl_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_lvl_in    = rsp_lvl_ff;

      ram_we        = 1'b0;
      ram_waddr     = cnt_ff[IDX_W-1:0];
      ram_wdata     = '{stamp: arrival_ff, bank: it_bank_ff, lvl: it_lvl_ff,
                        key: it_key_ff, id: it_id_ff};
      ram_raddr     = cnt_ff[IDX_W-1:0];

      lvl4 = 4'd0;
      bad  = 1'b0;
      elig = 1'b0;
      idx  = cnt_ff[IDX_W-1:0];
      wide = 4'd0;

      if (csr_write) begin
         if (paddr[2] == rqs_pkg::REG_LEVELS) begin
            levels_in = pwdata[3:0];
         end else begin
            policy_in = rqs_pkg::policy_type'(pwdata[1:0]);
         end
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               it_id_in  = req_bus.proc_id;
               it_key_in = TIME_BITS'(req_bus.remaining_time);
               res_id_in = req_bus.proc_id;
               res_lvl_in = '0;
               cnt_in    = '0;
               lag_live_in = 1'b0;
               if (req_bus.mode == rqs_pkg::MODE_ADD) begin
                  it_bank_in = active_ff;
                  if (policy_ff == rqs_pkg::POL_PRIO) begin
                     if (req_bus.dynamic_level[3]) begin
                        lvl4       = req_bus.static_level - 4'd1;
                        bad        = (req_bus.static_level == 4'd0) ||
                                     ({1'b0, req_bus.static_level} > lvl_count);
                        it_bank_in = ~active_ff;
                     end else begin
                        lvl4 = {1'b0, req_bus.dynamic_level[2:0]};
                        bad  = {2'b00, req_bus.dynamic_level[2:0]} >= lvl_count;
                     end
                  end
                  it_lvl_in = LVL_W'(lvl4);
                  if (bad) begin
                     res_status_in = rqs_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_ADD;
                  end
               end else begin
                  found_in = 1'b0;
                  act_in   = 1'b0;
                  exp_in   = 1'b0;
                  state_in = S_TAKE;
               end
            end
         end

         S_ADD: begin
            if (!valid_ff[idx]) begin
               ram_we        = 1'b1;
               valid_in[idx] = 1'b1;
               arrival_in    = arrival_ff + rqs_pkg::STAMP_W'(1);
               res_status_in = rqs_pkg::ST_OK;
               wide          = 4'(it_lvl_ff);
               res_lvl_in    = wide[2:0];
               state_in      = S_DONE;
            end else if (idx == IDX_W'(SLOTS - 1)) begin
               res_status_in = rqs_pkg::ST_FULL;
               state_in      = S_DONE;
            end else begin
               cnt_in = cnt_ff + (IDX_W + 1)'(1);
            end
         end

         S_TAKE, S_PICK: begin
            // issue one read, evaluate the word read in the previous cycle
            if (cnt_ff != (IDX_W + 1)'(SLOTS)) begin
               lag_live_in  = 1'b1;
               lag_idx_in   = idx;
               lag_valid_in = valid_ff[idx];
               cnt_in       = cnt_ff + (IDX_W + 1)'(1);
            end else begin
               lag_live_in = 1'b0;
            end

            if (lag_live_ff) begin
               if (policy_ff == rqs_pkg::POL_PRIO) begin
                  elig = lag_valid_ff && cand_in_range && (cand.bank == active_ff);
                  if (state_ff == S_TAKE) begin
                     if (elig) begin
                        act_in = 1'b1;
                     end
                     if (lag_valid_ff && cand_in_range && (cand.bank != active_ff)) begin
                        exp_in = 1'b1;
                     end
                     elig = 1'b0;
                  end
               end else begin
                  elig = lag_valid_ff;
               end
               if (elig && better) begin
                  found_in    = 1'b1;
                  best_idx_in = lag_idx_ff;
                  best_id_in  = cand.id;
                  best_key_in = cand.key;
                  best_lvl_in = cand.lvl;
                  best_age_in = cand_age;
               end
            end

            if ((cnt_ff == (IDX_W + 1)'(SLOTS)) && !lag_live_ff) begin
               if ((state_ff == S_TAKE) && (policy_ff == rqs_pkg::POL_PRIO)) begin
                  if (!act_ff && !exp_ff) begin
                     res_status_in = rqs_pkg::ST_EMPTY;
                     res_id_in     = '0;
                     res_lvl_in    = '0;
                     state_in      = S_DONE;
                  end else begin
                     if (!act_ff) begin
                        active_in = ~active_ff;
                     end
                     cnt_in   = '0;
                     found_in = 1'b0;
                     state_in = S_PICK;
                  end
               end else begin
                  if (found_ff) begin
                     valid_in[best_idx_ff] = 1'b0;
                     res_status_in = rqs_pkg::ST_OK;
                     res_id_in     = best_id_ff;
                     wide          = 4'(best_lvl_ff);
                     res_lvl_in    = (policy_ff == rqs_pkg::POL_PRIO) ? wide[2:0] : '0;
                  end else begin
                     res_status_in = rqs_pkg::ST_EMPTY;
                     res_id_in     = '0;
                     res_lvl_in    = '0;
                  end
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_lvl_in    = res_lvl_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= rqs_pkg::POLICY_RST;
         levels_ff    <= rqs_pkg::LEVELS_RST;
         active_ff    <= 1'b0;
         arrival_ff   <= '0;
         valid_ff     <= '0;
         lag_live_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         levels_ff     <= levels_in;
         active_ff     <= active_in;
         arrival_ff    <= arrival_in;
         valid_ff      <= valid_in;
         lag_live_ff   <= lag_live_in;
         rsp_valid_ff  <= rsp_valid_in;
         it_id_ff      <= it_id_in;
         it_key_ff     <= it_key_in;
         it_lvl_ff     <= it_lvl_in;
         it_bank_ff    <= it_bank_in;
         cnt_ff        <= cnt_in;
         lag_valid_ff  <= lag_valid_in;
         lag_idx_ff    <= lag_idx_in;
         found_ff      <= found_in;
         best_idx_ff   <= best_idx_in;
         best_id_ff    <= best_id_in;
         best_key_ff   <= best_key_in;
         best_lvl_ff   <= best_lvl_in;
         best_age_ff   <= best_age_in;
         act_ff        <= act_in;
         exp_ff        <= exp_in;
         res_status_ff <= res_status_in;
         res_id_ff     <= res_id_in;
         res_lvl_ff    <= res_lvl_in;
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_lvl_ff    <= rsp_lvl_in;
      end
   end

endmodule
`default_nettype wire

>>> dv/tb_ready_queue_scheduler.sv
`timescale 1ns / 100ps
// Testbench of the ready queue scheduler: directed and random request words against
// a cycle-free predictor of the slot store, checked word by word on the response side.
// Depends on rqs_pkg, rqs_req_if, rqs_rsp_if and the ready_queue_scheduler top level.
module tb_ready_queue_scheduler;

   localparam int SLOT_COUNT     = 64;
   localparam int LEVEL_CAP      = 8;
   localparam int RANDOM_WORDS   = 800;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 2 * SLOT_COUNT + 8;

   typedef struct packed {
      logic        mode;
      logic [7:0]  pid;
      logic [15:0] rtime;
      logic [3:0]  dyn;
      logic [3:0]  stat;
   } request_type;

   typedef struct packed {
      rqs_pkg::status_type status;
      logic [7:0]          id;
      logic [2:0]          lvl;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [rqs_pkg::CSR_ADDR_W-1:0] paddr;
   logic [rqs_pkg::CSR_DATA_W-1:0] pwdata;
   logic [rqs_pkg::CSR_DATA_W-1:0] prdata;
   logic        pready;

   rqs_req_if req_if ();
   rqs_rsp_if rsp_if ();

   ready_queue_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // scheduler state as predicted
   bit          held       [SLOT_COUNT];
   logic [7:0]  held_id    [SLOT_COUNT];
   logic [15:0] held_key   [SLOT_COUNT];
   logic [2:0]  held_lvl   [SLOT_COUNT];
   bit          held_bank  [SLOT_COUNT];
   logic [31:0] held_stamp [SLOT_COUNT];
   logic [31:0] arrivals;
   bit          cur_bank;
   rqs_pkg::policy_type cur_policy;
   logic [3:0]  cur_levels;

   outcome_type expected_outcomes [$];
   int words_sent;
   int words_checked;
   int fail_count;
   int mismatch_count;
   int quiet_cycles;
   int burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int level_count();
      if (cur_levels == 4'd0) return 1;
      if (cur_levels > LEVEL_CAP) return LEVEL_CAP;
      return int'(cur_levels);
   endfunction

   function automatic logic [31:0] age_of(int i);
      return arrivals - held_stamp[i];
   endfunction

   function automatic bit eligible(int i, bit bank, int count);
      return held[i] && held_bank[i] == bank && held_lvl[i] < count;
   endfunction

   function automatic int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < SLOT_COUNT; i++) n += int'(held[i]);
      return n;
   endfunction

   function automatic outcome_type apply_request(request_type rq);
      outcome_type res;
      int count;
      int lv;
      int slot;
      int best;
      bit bank;
      bit seen_act;
      bit seen_exp;
      res.status = rqs_pkg::ST_OK;
      res.id = '0;
      res.lvl = '0;
      count = level_count();
      if (rq.mode == rqs_pkg::MODE_ADD) begin
         res.id = rq.pid;
         bank = cur_bank;
         lv = 0;
         if (cur_policy == rqs_pkg::POL_PRIO) begin
            lv = int'($signed(rq.dyn));
            if (lv < 0) begin
               lv = int'(rq.stat) - 1;
               bank = !cur_bank;
            end
            if (lv < 0 || lv >= count) res.status = rqs_pkg::ST_RANGE;
         end
         if (res.status == rqs_pkg::ST_OK) begin
            slot = -1;
            for (int i = 0; i < SLOT_COUNT; i++) if (!held[i] && slot < 0) slot = i;
            if (slot < 0) begin
               res.status = rqs_pkg::ST_FULL;
            end else begin
               held[slot] = 1'b1;
               held_id[slot] = rq.pid;
               held_key[slot] = rq.rtime;
               held_lvl[slot] = lv[2:0];
               held_bank[slot] = bank;
               held_stamp[slot] = arrivals;
               arrivals = arrivals + 32'd1;
               res.lvl = lv[2:0];
            end
         end
      end else begin
         best = -1;
         if (cur_policy == rqs_pkg::POL_PRIO) begin
            seen_act = 1'b0;
            seen_exp = 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (eligible(i, cur_bank, count)) seen_act = 1'b1;
               if (eligible(i, !cur_bank, count)) seen_exp = 1'b1;
            end
            if (!seen_act && seen_exp) cur_bank = !cur_bank;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!eligible(i, cur_bank, count)) continue;
               if (best < 0 || held_lvl[i] > held_lvl[best] ||
                   (held_lvl[i] == held_lvl[best] && age_of(i) > age_of(best)))
                  best = i;
            end
         end else begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!held[i]) continue;
               if (best < 0) begin
                  best = i;
               end else if (cur_policy == rqs_pkg::POL_LIFO) begin
                  if (age_of(i) < age_of(best)) best = i;
               end else if (cur_policy == rqs_pkg::POL_SRT) begin
                  if (held_key[i] < held_key[best] ||
                      (held_key[i] == held_key[best] && age_of(i) > age_of(best)))
                     best = i;
               end else begin
                  if (age_of(i) > age_of(best)) best = i;
               end
            end
         end
         if (best < 0) begin
            res.status = rqs_pkg::ST_EMPTY;
         end else begin
            res.id = held_id[best];
            if (cur_policy == rqs_pkg::POL_PRIO) res.lvl = held_lvl[best];
            held[best] = 1'b0;
         end
      end
      return res;
   endfunction

   // predict on request acceptance, compare on response acceptance
   always @(posedge clock) begin
      request_type rq;
      outcome_type want;
      outcome_type got;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_if.valid && req_if.ready) begin
            quiet_cycles = 0;
            rq.mode = req_if.mode;
            rq.pid = req_if.proc_id;
            rq.rtime = req_if.remaining_time;
            rq.dyn = req_if.dynamic_level;
            rq.stat = req_if.static_level;
            want = apply_request(rq);
            expected_outcomes.insert(expected_outcomes.size(), want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            got.status = rqs_pkg::status_type'(rsp_if.status);
            got.id = rsp_if.out_id;
            got.lvl = rsp_if.out_level;
            if (expected_outcomes.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word status %0d id %0d level %0d",
                           $realtime, got.status, got.id, got.lvl);
            end else begin
               want = expected_outcomes.pop_front();
               if (got.status !== want.status || got.id !== want.id ||
                   got.lvl !== want.lvl) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: status exp %0d got %0d, id exp %0d got %0d, %s %0d got %0d",
                              $realtime, want.status, got.status, want.id, got.id,
                              "level exp", want.lvl, got.lvl);
               end
            end
            words_checked++;
         end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stalls in stretches of changing style
   initial begin
      int stretch;
      int style;
      rsp_if.ready <= 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         stretch = $urandom_range(16, 200);
         for (int tick = 0; tick < stretch; tick++) begin
            @(posedge clock);
            case (style)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= (tick % 5 == 0);
               default: rsp_if.ready <= ($urandom_range(0, 39) == 0);
            endcase
         end
      end
   end

   task automatic send_word(request_type rq);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(13, 160)) @(posedge clock);
            else repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.mode <= rq.mode;
      req_if.proc_id <= rq.pid;
      req_if.remaining_time <= rq.rtime;
      req_if.dynamic_level <= rq.dyn;
      req_if.static_level <= rq.stat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (words_checked < words_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx == rqs_pkg::REG_POLICY) cur_policy = rqs_pkg::policy_type'(value[1:0]);
      else cur_levels = value[3:0];
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_policy(rqs_pkg::policy_type pol);
      wait_idle();
      csr_write(rqs_pkg::REG_POLICY, {30'd0, pol});
   endtask

   task automatic set_levels(logic [3:0] lv);
      wait_idle();
      csr_write(rqs_pkg::REG_LEVELS, {28'd0, lv});
   endtask

   function automatic request_type add_word(logic [7:0] pid, logic [15:0] rtime,
                                            int dyn, int stat);
      request_type rq;
      rq.mode = rqs_pkg::MODE_ADD;
      rq.pid = pid;
      rq.rtime = rtime;
      rq.dyn = dyn[3:0];
      rq.stat = stat[3:0];
      return rq;
   endfunction

   function automatic request_type take_word();
      request_type rq;
      rq.mode = rqs_pkg::MODE_TAKE;
      rq.pid = 8'($urandom);
      rq.rtime = 16'($urandom);
      rq.dyn = 4'($urandom);
      rq.stat = 4'($urandom);
      return rq;
   endfunction

   function automatic request_type random_word(int bias);
      request_type rq;
      int occ;
      int add_pct;
      int count;
      occ = occupancy();
      count = level_count();
      case (bias)
         0: add_pct = 85;
         1: add_pct = 25;
         default: add_pct = (occ < 8) ? 70 : ((occ > 56) ? 30 : 50);
      endcase
      rq = take_word();
      if ($urandom_range(0, 99) < add_pct) rq.mode = rqs_pkg::MODE_ADD;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: rq.rtime = 16'($urandom_range(0, 7));
         4: rq.rtime = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: rq.rtime = 16'($urandom);
      endcase
      if ($urandom_range(0, 9) != 0) begin
         rq.stat = 4'($urandom_range(1, count));
         if ($urandom_range(0, 3) == 0) rq.dyn = 4'hF;
         else rq.dyn = 4'($urandom_range(0, count - 1));
      end
      return rq;
   endfunction

   task automatic test_plain_orders();
      set_policy(rqs_pkg::POL_FIFO);
      send_word(take_word());
      send_word(add_word(8'h00, 16'h0000, 0, 0));
      send_word(add_word(8'hFF, 16'hFFFF, 7, 15));
      send_word(add_word(8'h5A, 16'h1234, -8, 8));
      send_word(take_word());
      set_policy(rqs_pkg::POL_LIFO);
      send_word(take_word());
      send_word(add_word(8'hA5, 16'h8000, 3, 1));
      send_word(take_word());
      send_word(take_word());
      send_word(take_word());
   endtask

   task automatic test_shortest_remaining();
      set_policy(rqs_pkg::POL_SRT);
      send_word(add_word(8'h11, 16'd7, 0, 1));
      send_word(add_word(8'h22, 16'd0, 0, 1));
      send_word(add_word(8'h33, 16'hFFFF, 0, 1));
      send_word(add_word(8'h44, 16'd7, 0, 1));
      send_word(add_word(8'h55, 16'd0, 0, 1));
      repeat (6) send_word(take_word());
   endtask

   task automatic test_priority_banks();
      set_policy(rqs_pkg::POL_PRIO);
      set_levels(4'd4);
      send_word(add_word(8'h01, 16'd9, 3, 2));
      send_word(add_word(8'h02, 16'd9, 0, 2));
      send_word(add_word(8'h03, 16'd9, -1, 4));
      send_word(add_word(8'h04, 16'd9, -1, 1));
      send_word(add_word(8'h05, 16'd9, 4, 2));
      send_word(add_word(8'h06, 16'd9, -8, 15));
      send_word(add_word(8'h07, 16'd9, -1, 0));
      send_word(add_word(8'h08, 16'd9, 7, 5));
      repeat (5) send_word(take_word());
      // hide an entry above the level count, then widen the count again
      send_word(add_word(8'h09, 16'd9, 3, 2));
      set_levels(4'd2);
      send_word(take_word());
      set_levels(4'd0);
      send_word(take_word());
      set_levels(4'd15);
      send_word(add_word(8'h0A, 16'd9, 7, 2));
      repeat (3) send_word(take_word());
   endtask

   task automatic test_store_full();
      request_type rq;
      set_policy(rqs_pkg::policy_type'($urandom_range(0, 2)));
      repeat (SLOT_COUNT + 2) begin
         rq = random_word(0);
         rq.mode = rqs_pkg::MODE_ADD;
         send_word(rq);
      end
      set_policy(rqs_pkg::POL_PRIO);
      set_levels(4'd8);
      send_word(add_word(8'hC3, 16'd1, 2, 3));
      repeat (SLOT_COUNT / 2) send_word(take_word());
      set_policy(rqs_pkg::POL_FIFO);
      repeat (SLOT_COUNT / 2 + 1) send_word(take_word());
   endtask

   task automatic test_random_traffic();
      int sent;
      int plen;
      int bias;
      logic [31:0] junk;
      logic [3:0] lv;
      rqs_pkg::policy_type pol;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         wait_idle();
         pol = rqs_pkg::policy_type'($urandom_range(0, 3));
         junk = $urandom;
         csr_write(rqs_pkg::REG_POLICY, {junk[31:2], pol});
         case ($urandom_range(0, 5))
            0: lv = 4'd0;
            1: lv = 4'd1;
            2: lv = 4'd8;
            3: lv = 4'd15;
            default: lv = 4'($urandom_range(0, 15));
         endcase
         junk = $urandom;
         csr_write(rqs_pkg::REG_LEVELS, {junk[31:4], lv});
         bias = $urandom_range(0, 3);
         plen = $urandom_range(20, 90);
         repeat (plen) send_word(random_word(bias));
         sent += plen;
      end
   endtask

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) held[i] = 1'b0;
      arrivals = '0;
      cur_bank = 1'b0;
      cur_policy = rqs_pkg::POLICY_RST;
      cur_levels = rqs_pkg::LEVELS_RST;
      words_sent = 0;
      words_checked = 0;
      fail_count = 0;
      mismatch_count = 0;
      burst_left = 0;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_if.valid <= 1'b0;
      req_if.mode <= rqs_pkg::MODE_ADD;
      req_if.proc_id <= '0;
      req_if.remaining_time <= '0;
      req_if.dynamic_level <= '0;
      req_if.static_level <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_orders();
      test_shortest_remaining();
      test_priority_banks();
      test_store_full();
      test_random_traffic();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_outcomes.size() != 0) fail_count++;
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
src/rqs_pkg.sv
src/rqs_req_if.sv
src/rqs_rsp_if.sv
src/rqs_ram.sv
src/ready_queue_scheduler.sv
dv/tb_ready_queue_scheduler.sv
